/* sv/hnhp_pkg.sv */
// ----------------------------------------------------------------------------
// hnhp_pkg
// Shared types, hash constants and saturation/value tables of the hashed
// noise HSV pixel generator.
// ----------------------------------------------------------------------------
package hnhp_pkg;

    // coordinate width carried by the input transfer
    localparam int COORD_BITS = 12;

    // number of register stages from input transfer to output register
    localparam int PIPE_DEPTH = 7;

    // command codes
    localparam logic CMD_FILL    = 1'b0;
    localparam logic CMD_OVERLAY = 1'b1;

    // register map, indexed by word address
    typedef enum logic {
        REG_NOISE_SEED    = 1'b0,
        REG_OVERLAY_ALPHA = 1'b1
    } reg_index_t;

    localparam logic [31:0] NOISE_SEED_RST    = 32'd0;
    localparam logic [7:0]  OVERLAY_ALPHA_RST = 8'hFF;
    localparam logic [7:0]  FILL_ALPHA        = 8'hFF;

    // multiplicative hash constants
    localparam logic [31:0] MUL_X_FILL = 32'd374761393;
    localparam logic [31:0] MUL_Y_FILL = 32'd668265263;
    localparam logic [31:0] GOLDEN     = 32'h9E3779B9;
    localparam logic [31:0] MUL_MIX    = 32'd1274126177;
    localparam logic [31:0] MUL_X_OVL  = 32'd2654435761;
    localparam logic [31:0] MUL_Y_OVL  = 32'd974634777;
    localparam logic [31:0] MUL_SEED   = 32'd668265263;

    // hue circle: one sector spans 65535 steps of six times the hue
    localparam logic [15:0] HUE_MAX  = 16'hFFFF;
    localparam logic [18:0] SECT_B1  = 19'(1 * 65535);
    localparam logic [18:0] SECT_B2  = 19'(2 * 65535);
    localparam logic [18:0] SECT_B3  = 19'(3 * 65535);
    localparam logic [18:0] SECT_B4  = 19'(4 * 65535);
    localparam logic [18:0] SECT_B5  = 19'(5 * 65535);

    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } hue_sector_t;

    // Q1.16 saturation / value tables, 1.0 = 65536
    typedef logic [255:0][16:0] sv_tab_t;
    typedef logic [127:0][16:0] sv_half_tab_t;

    // 65536*(255+t)/510
    function automatic sv_tab_t build_half_tab();
        sv_tab_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = 17'((65536 * (255 + i)) / 510);
        end
        return tab;
    endfunction

    // 65536*(510+3t)/1275
    function automatic sv_tab_t build_fill_v_tab();
        sv_tab_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = 17'((65536 * (510 + 3 * i)) / 1275);
        end
        return tab;
    endfunction

    // 65536*(765+2t)/1275
    function automatic sv_half_tab_t build_ovl_s_tab();
        sv_half_tab_t tab;
        for (int i = 0; i < 128; i++)
        begin
            tab[i] = 17'((65536 * (765 + 2 * i)) / 1275);
        end
        return tab;
    endfunction

    localparam sv_tab_t      HALF_TAB   = build_half_tab();
    localparam sv_tab_t      FILL_V_TAB = build_fill_v_tab();
    localparam sv_half_tab_t OVL_S_TAB  = build_ovl_s_tab();

    // input and output transfers
    typedef struct packed {
        logic                  command;
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
    } coord_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } pixel_t;

    // hash unit to hsv unit
    typedef struct packed {
        logic        ovl;
        logic [31:0] h;
        logic [7:0]  alpha;
    } hash_t;

    // hsv unit to colour unit
    typedef struct packed {
        hue_sector_t sector;
        logic [16:0] f;
        logic [16:0] c;
        logic [16:0] v;
        logic [7:0]  alpha;
    } hsv_t;

endpackage

/* sv/hnhp_hash.sv */
// ----------------------------------------------------------------------------
// hnhp_hash
// Three-stage multiplicative hash: coordinate products, combine and fold,
// final mixing multiply.
// ----------------------------------------------------------------------------
module hnhp_hash
    import hnhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        up_ready,
    input  coord_t      coord,
    input  logic [31:0] noise_seed,
    input  logic [7:0]  overlay_alpha,
    output logic        out_valid,
    input  logic        down_ready,
    output hash_t       hash
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s1_ready, s2_ready, s3_ready;
    logic [31:0] p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;
    logic        s1_ovl_reg, s2_ovl_reg, s3_ovl_reg;
    logic [7:0]  s1_alpha_reg, s2_alpha_reg, s3_alpha_reg, alpha_next;
    logic [31:0] h1_reg, h1_next, h0;
    logic [31:0] h2_reg, h2_next;
    logic [31:0] x_ext, y_ext, xo_ext, yo_ext;

    // stage enables
    assign s3_ready = !s3_valid_reg || down_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    // stage 1: coordinate and seed products
    always_comb
    begin
        x_ext  = 32'(coord.x_coord);
        y_ext  = 32'(coord.y_coord);
        xo_ext = 32'({coord.x_coord[COORD_BITS-1:2], 2'b00});
        yo_ext = 32'({coord.y_coord[COORD_BITS-1:2], 2'b00});
        if (coord.command == CMD_OVERLAY)
        begin
            p0_next    = 32'(xo_ext * MUL_X_OVL);
            p1_next    = 32'(yo_ext * MUL_Y_OVL);
            alpha_next = overlay_alpha;
        end
        else
        begin
            p0_next    = 32'(x_ext * MUL_X_FILL);
            p1_next    = 32'(y_ext * MUL_Y_FILL);
            alpha_next = FILL_ALPHA;
        end
        p2_next = 32'(noise_seed * MUL_SEED);
    end

    // stage 2: combine and first fold
    always_comb
    begin
        if (s1_ovl_reg)
        begin
            h0 = p0_reg ^ p1_reg ^ p2_reg;
        end
        else
        begin
            h0 = p0_reg + p1_reg + GOLDEN;
        end
        h1_next = h0 ^ (h0 >> 13);
    end

    // stage 3: mixing multiply
    assign h2_next = 32'(h1_reg * MUL_MIX);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            p0_reg       <= p0_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            s1_ovl_reg   <= (coord.command == CMD_OVERLAY);
            s1_alpha_reg <= alpha_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            h1_reg       <= h1_next;
            s2_ovl_reg   <= s1_ovl_reg;
            s2_alpha_reg <= s1_alpha_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            h2_reg       <= h2_next;
            s3_ovl_reg   <= s2_ovl_reg;
            s3_alpha_reg <= s2_alpha_reg;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign hash.ovl   = s3_ovl_reg;
    assign hash.h     = h2_reg;
    assign hash.alpha = s3_alpha_reg;

endmodule

/* sv/hnhp_hsv.sv */
// ----------------------------------------------------------------------------
// hnhp_hsv
// Two stages: final fold and S/V table lookup, then hue sector split,
// ramp fraction and chroma multiply.
// ----------------------------------------------------------------------------
module hnhp_hsv
    import hnhp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  up_ready,
    input  hash_t hash,
    output logic  out_valid,
    input  logic  down_ready,
    output hsv_t  hsv
);

    logic        s4_valid_reg, s5_valid_reg;
    logic        s4_ready, s5_ready;
    logic [31:0] h;
    logic [15:0] hue;
    logic [18:0] h6_reg, h6_next;
    logic [16:0] s4_s_reg, s4_v_reg, s_next, v_next;
    logic [7:0]  s4_alpha_reg;
    hue_sector_t sector_next;
    logic [18:0] base;
    logic [18:0] rem;
    logic [15:0] ramp;
    logic [16:0] f_next;
    logic [33:0] vs_prod;
    hsv_t        s5_reg, s5_next;

    // stage enables
    assign s5_ready = !s5_valid_reg || down_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign up_ready = s4_ready;

    // stage 4: final fold, hue wrap, saturation and value lookup
    always_comb
    begin
        h = hash.ovl ? (hash.h ^ (hash.h >> 16)) : hash.h;
        hue = (h[15:0] == HUE_MAX) ? 16'd0 : h[15:0];
        h6_next = 19'({hue, 2'b00}) + 19'({hue, 1'b0});
        if (hash.ovl)
        begin
            s_next = OVL_S_TAB[h[23:17]];
            v_next = HALF_TAB[h[31:24]];
        end
        else
        begin
            s_next = HALF_TAB[h[23:16]];
            v_next = FILL_V_TAB[h[31:24]];
        end
    end

    // stage 5: sector, remainder, ramp fraction and chroma multiply
    always_comb
    begin
        if (h6_reg >= SECT_B5)
        begin
            sector_next = SECT_5;
            base        = SECT_B5;
        end
        else if (h6_reg >= SECT_B4)
        begin
            sector_next = SECT_4;
            base        = SECT_B4;
        end
        else if (h6_reg >= SECT_B3)
        begin
            sector_next = SECT_3;
            base        = SECT_B3;
        end
        else if (h6_reg >= SECT_B2)
        begin
            sector_next = SECT_2;
            base        = SECT_B2;
        end
        else if (h6_reg >= SECT_B1)
        begin
            sector_next = SECT_1;
            base        = SECT_B1;
        end
        else
        begin
            sector_next = SECT_0;
            base        = 19'd0;
        end
        rem = h6_reg - base;
        // falling ramp in odd sectors
        if (sector_next == SECT_1 || sector_next == SECT_3 || sector_next == SECT_5)
        begin
            ramp = HUE_MAX - rem[15:0];
        end
        else
        begin
            ramp = rem[15:0];
        end
        // ramp*65536/65535 only gains one at full scale
        f_next = 17'(ramp) + 17'(ramp == HUE_MAX);
        vs_prod = s4_v_reg * s4_s_reg;
        s5_next.sector = sector_next;
        s5_next.f      = f_next;
        s5_next.c      = vs_prod[32:16];
        s5_next.v      = s4_v_reg;
        s5_next.alpha  = s4_alpha_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= in_valid;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s4_ready && in_valid)
        begin
            h6_reg       <= h6_next;
            s4_s_reg     <= s_next;
            s4_v_reg     <= v_next;
            s4_alpha_reg <= hash.alpha;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign hsv       = s5_reg;

endmodule

/* sv/hnhp_rgb.sv */
// ----------------------------------------------------------------------------
// hnhp_rgb
// Two stages: secondary component and offset, then sector routing, scaling
// to eight bits and the output register.
// ----------------------------------------------------------------------------
module hnhp_rgb
    import hnhp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   up_ready,
    input  hsv_t   hsv,
    output logic   out_valid,
    input  logic   down_ready,
    output pixel_t pixel
);

    logic        s6_valid_reg, s7_valid_reg;
    logic        s6_ready, s7_ready;
    hue_sector_t s6_sector_reg;
    logic [16:0] s6_c_reg, s6_x_reg, s6_m_reg;
    logic [7:0]  s6_alpha_reg;
    logic [33:0] cf_prod;
    logic [16:0] x_next, m_next;
    logic [16:0] r_comp, g_comp, b_comp;
    pixel_t      pixel_reg, pixel_next;

    // scale a Q1.16 channel to a byte, saturating
    function automatic logic [7:0] to_byte(input logic [16:0] comp, input logic [16:0] m);
        logic [16:0] sum;
        logic [24:0] scaled;
        sum    = comp + m;
        scaled = {sum, 8'd0} - 25'(sum);
        return (scaled[24:16] > 9'd255) ? 8'hFF : scaled[23:16];
    endfunction

    // stage enables
    assign s7_ready = !s7_valid_reg || down_ready;
    assign s6_ready = !s6_valid_reg || s7_ready;
    assign up_ready = s6_ready;

    // stage 6: secondary component and offset
    always_comb
    begin
        cf_prod = hsv.c * hsv.f;
        x_next  = cf_prod[32:16];
        m_next  = hsv.v - hsv.c;
    end

    // stage 7: route components by sector and scale
    always_comb
    begin
        case (s6_sector_reg)
            SECT_0:
            begin
                r_comp = s6_c_reg;
                g_comp = s6_x_reg;
                b_comp = 17'd0;
            end
            SECT_1:
            begin
                r_comp = s6_x_reg;
                g_comp = s6_c_reg;
                b_comp = 17'd0;
            end
            SECT_2:
            begin
                r_comp = 17'd0;
                g_comp = s6_c_reg;
                b_comp = s6_x_reg;
            end
            SECT_3:
            begin
                r_comp = 17'd0;
                g_comp = s6_x_reg;
                b_comp = s6_c_reg;
            end
            SECT_4:
            begin
                r_comp = s6_x_reg;
                g_comp = 17'd0;
                b_comp = s6_c_reg;
            end
            default:
            begin
                r_comp = s6_c_reg;
                g_comp = 17'd0;
                b_comp = s6_x_reg;
            end
        endcase
        pixel_next.red       = to_byte(r_comp, s6_m_reg);
        pixel_next.green     = to_byte(g_comp, s6_m_reg);
        pixel_next.blue      = to_byte(b_comp, s6_m_reg);
        pixel_next.alpha_out = s6_alpha_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (s6_ready)
            begin
                s6_valid_reg <= in_valid;
            end
            if (s7_ready)
            begin
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s6_ready && in_valid)
        begin
            s6_sector_reg <= hsv.sector;
            s6_c_reg      <= hsv.c;
            s6_x_reg      <= x_next;
            s6_m_reg      <= m_next;
            s6_alpha_reg  <= hsv.alpha;
        end
        if (s7_ready && s6_valid_reg)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = s7_valid_reg;
    assign pixel     = pixel_reg;

endmodule

/* sv/hashed_noise_hsv_pixel_generator.sv */
// ----------------------------------------------------------------------------
// hashed_noise_hsv_pixel_generator
// Hashed noise pixel generator: coordinate hash to HSV to RGBA, with an
// APB register port for the overlay seed and alpha.
// ----------------------------------------------------------------------------
// Each coordinate transfer yields one RGBA pixel transfer through the
// seven-stage pipeline (three hash stages, two HSV stages, two colour
// stages). While the pixel side does not stall, a new coordinate is taken
// in every cycle, so the sustained rate is one pixel per clock. Stalls on
// the pixel side fill the empty stages before coord_stall is raised.
// Command 0 gives dense fill noise with alpha 255; command 1 gives 4x4 block
// noise mixed with noise_seed and alpha from overlay_alpha. Registers:
// noise_seed at byte address 0, overlay_alpha at byte address 4; write them
// only while no pixel is in flight.
module hashed_noise_hsv_pixel_generator
    import hnhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // coordinate channel
    input  logic        coord_valid,
    output logic        coord_stall,
    input  coord_t      coord,
    // pixel channel
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output pixel_t      pixel,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] noise_seed_reg;
    logic [7:0]  overlay_alpha_reg;
    logic        cfg_write;
    reg_index_t  cfg_index;
    logic        hash_ready, hash_valid;
    logic        hsv_ready, hsv_valid;
    logic        rgb_ready;
    hash_t       hash;
    hsv_t        hsv;

    // register port decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg    <= NOISE_SEED_RST;
            overlay_alpha_reg <= OVERLAY_ALPHA_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NOISE_SEED:    noise_seed_reg    <= pwdata;
                REG_OVERLAY_ALPHA: overlay_alpha_reg <= pwdata[7:0];
                default:           noise_seed_reg    <= noise_seed_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_index)
            REG_NOISE_SEED:    prdata = noise_seed_reg;
            REG_OVERLAY_ALPHA: prdata = {24'd0, overlay_alpha_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // hash stages
    hnhp_hash u_hash (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (coord_valid),
        .up_ready      (hash_ready),
        .coord         (coord),
        .noise_seed    (noise_seed_reg),
        .overlay_alpha (overlay_alpha_reg),
        .out_valid     (hash_valid),
        .down_ready    (hsv_ready),
        .hash          (hash)
    );

    // hsv stages
    hnhp_hsv u_hsv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hash_valid),
        .up_ready   (hsv_ready),
        .hash       (hash),
        .out_valid  (hsv_valid),
        .down_ready (rgb_ready),
        .hsv        (hsv)
    );

    // colour stages and output register
    hnhp_rgb u_rgb (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hsv_valid),
        .up_ready   (rgb_ready),
        .hsv        (hsv),
        .out_valid  (pixel_valid),
        .down_ready (!pixel_stall),
        .pixel      (pixel)
    );

    assign coord_stall = !hash_ready;

    // input only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> (pixel_valid && pixel_stall))
        else $error("coordinate stall raised with room in the pipeline");

    // a pixel appearing at an empty output has flowed straight through
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid) |-> $past(coord_valid && !coord_stall, PIPE_DEPTH))
        else $error("pixel appeared without a matching coordinate transfer");

    // overlay alpha write takes effect at the next edge
    a_alpha_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == REG_OVERLAY_ALPHA)
        |=> (overlay_alpha_reg == $past(pwdata[7:0])))
        else $error("overlay alpha register write lost");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hashed noise HSV pixel generator. Coordinates
// are fed from a queue through a valid/stall driver with random gaps. Each
// accepted transfer is run through a local hash and HSV colour predictor.
// A monitor with random stalls checks every pixel field against the oldest
// prediction. Phases step through seed and alpha settings written over APB,
// one of them with a long hold-off on the pixel side to back up the pipeline.
// ----------------------------------------------------------------------------
module tb;
    import hnhp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 200;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    typedef struct {
        coord_t      item;
        int unsigned gap;
    } queued_coord_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        coord_valid = 1'b0;
    logic        coord_stall;
    coord_t      coord = '0;
    logic        pixel_valid;
    logic        pixel_stall = 1'b0;
    pixel_t      pixel;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // register copies used for prediction
    logic [31:0] seed_shadow = NOISE_SEED_RST;
    logic [7:0]  alpha_shadow = OVERLAY_ALPHA_RST;

    queued_coord_t coord_queue[$];
    pixel_t        pixel_queue[$];

    int unsigned tx_gap_max = 0;
    int unsigned rx_gap_max = 0;
    int unsigned tx_wait;
    int unsigned rx_hold;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          pressure_go = 1'b0;
    logic        hold_active;

    hashed_noise_hsv_pixel_generator uut (.*);

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] fill_hash(logic [COORD_BITS-1:0] x,
                                              logic [COORD_BITS-1:0] y);
        logic [31:0] h;
        h = 32'(x) * MUL_X_FILL + 32'(y) * MUL_Y_FILL + GOLDEN;
        h = (h ^ (h >> 13)) * MUL_MIX;
        return h;
    endfunction

    function automatic logic [31:0] overlay_hash(logic [COORD_BITS-1:0] x,
                                                 logic [COORD_BITS-1:0] y,
                                                 logic [31:0] seed);
        logic [31:0] h;
        // snap to the 4x4 block grid
        h = (32'({x[COORD_BITS-1:2], 2'b00}) * MUL_X_OVL)
            ^ (32'({y[COORD_BITS-1:2], 2'b00}) * MUL_Y_OVL)
            ^ (seed * MUL_SEED);
        h = h ^ (h >> 13);
        h = h * MUL_MIX;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [7:0] to_channel(logic [63:0] comp, logic [63:0] base);
        logic [63:0] level;
        level = ((comp + base) * 64'd255) >> 16;
        return (level > 64'd255) ? 8'hFF : level[7:0];
    endfunction

    function automatic pixel_t paint_pixel(coord_t c, logic [31:0] seed,
                                           logic [7:0] alpha);
        logic [31:0] h;
        logic [15:0] hue;
        logic [63:0] sat, val, h6, sect, rem, ramp, frac, chroma, mid, base;
        logic [63:0] r, g, b;
        hue_sector_t sector;
        pixel_t      p;

        if (c.command == CMD_FILL)
        begin
            h = fill_hash(c.x_coord, c.y_coord);
            sat = (64'd65536 * (64'd255 + 64'(h[23:16]))) / 64'd510;
            val = (64'd65536 * (64'd510 + 64'd3 * 64'(h[31:24]))) / 64'd1275;
            p.alpha_out = FILL_ALPHA;
        end
        else
        begin
            h = overlay_hash(c.x_coord, c.y_coord, seed);
            sat = (64'd65536 * (64'd765 + 64'd2 * 64'(h[23:17]))) / 64'd1275;
            val = (64'd65536 * (64'd255 + 64'(h[31:24]))) / 64'd510;
            p.alpha_out = alpha;
        end

        // hue 1.0 wraps to the start of the circle
        hue = (h[15:0] == HUE_MAX) ? 16'd0 : h[15:0];
        h6 = 64'(hue) * 64'd6;
        sect = h6 / 64'd65535;
        rem = h6 % 64'd65535;
        ramp = sect[0] ? (64'd65535 - rem) : rem;
        frac = (ramp * 64'd65536) / 64'd65535;
        chroma = (val * sat) >> 16;
        mid = (chroma * frac) >> 16;
        base = val - chroma;

        sector = hue_sector_t'(sect[2:0]);
        case (sector)
            SECT_0:
            begin
                r = chroma;
                g = mid;
                b = 64'd0;
            end
            SECT_1:
            begin
                r = mid;
                g = chroma;
                b = 64'd0;
            end
            SECT_2:
            begin
                r = 64'd0;
                g = chroma;
                b = mid;
            end
            SECT_3:
            begin
                r = 64'd0;
                g = mid;
                b = chroma;
            end
            SECT_4:
            begin
                r = mid;
                g = 64'd0;
                b = chroma;
            end
            default:
            begin
                r = chroma;
                g = 64'd0;
                b = mid;
            end
        endcase

        p.red = to_channel(r, base);
        p.green = to_channel(g, base);
        p.blue = to_channel(b, base);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // coordinate driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : coord_source
        queued_coord_t head;
        if (!rst_n)
        begin
            coord_valid <= 1'b0;
            coord <= '0;
            tx_wait <= 0;
        end
        else
        begin
            // predict on every accepted transfer
            if (coord_valid && !coord_stall)
            begin
                pixel_queue.push_back(paint_pixel(coord, seed_shadow, alpha_shadow));
            end

            // bus free once idle or just taken
            if (!coord_valid || !coord_stall)
            begin
                if (coord_queue.size() > 0 && tx_wait >= coord_queue[0].gap)
                begin
                    head = coord_queue.pop_front();
                    coord <= head.item;
                    coord_valid <= 1'b1;
                    tx_wait <= 0;
                end
                else
                begin
                    coord_valid <= 1'b0;
                    tx_wait <= (coord_queue.size() > 0) ? tx_wait + 1 : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pixel monitor
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : pixel_sink
        int unsigned next_hold;
        pixel_t      want;
        if (!rst_n)
        begin
            pixel_stall <= 1'b0;
            rx_hold <= 0;
        end
        else
        begin
            next_hold = rx_hold;
            if (pixel_valid && !pixel_stall)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $error("pixel transfer with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    check_field("red", want.red, pixel.red);
                    check_field("green", want.green, pixel.green);
                    check_field("blue", want.blue, pixel.blue);
                    check_field("alpha_out", want.alpha_out, pixel.alpha_out);
                end
                next_hold = $urandom_range(0, rx_gap_max);
            end
            else if (next_hold > 0)
            begin
                next_hold = next_hold - 1;
            end
            rx_hold <= next_hold;
            pixel_stall <= hold_active || (next_hold > 0);
        end
    end

    // long hold-off on the pixel side so the pipeline backs up
    initial
    begin
        hold_active = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hashed_noise_hsv_pixel_generator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic write_reg(reg_index_t idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        // register taken at this edge
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_NOISE_SEED)
            seed_shadow <= data;
        else
            alpha_shadow <= data[7:0];
    endtask

    task automatic queue_coord(logic cmd, int x, int y);
        queued_coord_t entry;
        entry.item.command = cmd;
        entry.item.x_coord = COORD_BITS'(x);
        entry.item.y_coord = COORD_BITS'(y);
        entry.gap = $urandom_range(0, tx_gap_max);
        coord_queue.push_back(entry);
    endtask

    // mostly uniform, now and then a block or range edge
    function automatic int pick_coord();
        int edges[4];
        edges = '{0, 3, COORD_MAX - 3, COORD_MAX};
        if ($urandom_range(0, 7) == 0)
            return edges[$urandom_range(0, 3)];
        return $urandom_range(0, COORD_MAX);
    endfunction

    // look for a coordinate whose hue field is exactly 1.0
    task automatic queue_full_hue(logic cmd);
        int          step;
        logic [31:0] h;
        bit          found;
        found = 1'b0;
        step = (cmd == CMD_OVERLAY) ? 4 : 1;
        for (int y = 0; y <= COORD_MAX && !found; y += step)
        begin
            for (int x = 0; x <= COORD_MAX && !found; x += step)
            begin
                if (cmd == CMD_FILL)
                    h = fill_hash(COORD_BITS'(x), COORD_BITS'(y));
                else
                    h = overlay_hash(COORD_BITS'(x), COORD_BITS'(y), seed_shadow);
                if (h[15:0] == HUE_MAX)
                begin
                    queue_coord(cmd, x, y);
                    found = 1'b1;
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (coord_queue.size() != 0 || coord_valid || pixel_queue.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic run_phase(logic [31:0] seed, logic [31:0] alpha_word,
                             int unsigned tx_max, int unsigned rx_max,
                             int count, bit back_up);
        write_reg(REG_NOISE_SEED, seed);
        write_reg(REG_OVERLAY_ALPHA, alpha_word);
        @(negedge clk);
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        for (int i = 0; i < count; i++)
            queue_coord(1'($urandom_range(0, 1)), pick_coord(), pick_coord());
        if (back_up)
            pressure_go = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: range corners in both modes, block rounding, hue wrap
        tx_gap_max = 2;
        rx_gap_max = 2;
        for (int m = 0; m < 2; m++)
        begin
            queue_coord(m[0], 0, 0);
            queue_coord(m[0], COORD_MAX, COORD_MAX);
            queue_coord(m[0], 0, COORD_MAX);
            queue_coord(m[0], COORD_MAX, 0);
        end
        queue_coord(CMD_OVERLAY, 3, 2);
        queue_coord(CMD_OVERLAY, 1, 3);
        queue_coord(CMD_OVERLAY, COORD_MAX - 3, COORD_MAX - 1);
        queue_coord(CMD_OVERLAY, 'hAAA, 'h555);
        queue_coord(CMD_FILL, 'h555, 'hAAA);
        queue_full_hue(CMD_FILL);
        queue_full_hue(CMD_OVERLAY);
        wait_drained();

        // random phases over seed and alpha settings, extremes first;
        // the alpha write carries junk in its upper bits
        run_phase(32'hFFFF_FFFF, 32'hABCD_1200, 14, 14, 250, 1'b0);
        run_phase($urandom, $urandom, 0, 0, 250, 1'b0);
        run_phase(32'h0000_0000, 32'h0000_00FF, 3, 14, 250, 1'b0);
        run_phase($urandom, 32'h0000_0080, 0, 0, 300, 1'b1);
        run_phase($urandom, $urandom, 14, 0, 350, 1'b0);

        if (mismatches == 0)
            $display("hashed_noise_hsv_pixel_generator verification clean");
        else
            $display("hashed_noise_hsv_pixel_generator verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/hnhp_pkg.sv
sv/hnhp_hash.sv
sv/hnhp_hsv.sv
sv/hnhp_rgb.sv
sv/hashed_noise_hsv_pixel_generator.sv
test/tb.sv
